// ===== rtl/core/connection_innovation_registry_unit_assert.svh =====
// Assertion macros for the connection innovation registry.
// Used by the top level only; no other dependencies.
`ifndef CONNECTION_INNOVATION_REGISTRY_UNIT_ASSERT_SVH
`define CONNECTION_INNOVATION_REGISTRY_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Checks a condition in the same cycle as its trigger.
`define CIR_ASSERT_SAME(lbl, clk_i, rstn_i, ante, cons) \
    lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
        else $error("connection innovation registry check failed");
// Checks a condition in the cycle after its trigger.
`define CIR_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons) \
    lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
        else $error("connection innovation registry check failed");
`else
`define CIR_ASSERT_SAME(lbl, clk_i, rstn_i, ante, cons)
`define CIR_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons)
`endif
`endif

// ===== rtl/core/cir_pkg.sv =====
// Shared types and constants for the connection innovation registry.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package cir_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 256;
    localparam int DEFAULT_NODE_BITS   = 16;

    localparam int NODE_W      = 16;
    localparam int COUNT_W     = 11;
    localparam int INDEX_W     = 8;
    localparam int STATUS_W    = 2;
    localparam int CFG_INDEX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_INPUT_COUNT  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_COUNT = 2'd1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_TARGET_IN  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SOURCE_OUT = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL       = 2'd3;

    // How a request finished.
    typedef enum logic [2:0] {
        KIND_TARGET,
        KIND_SOURCE,
        KIND_FOUND,
        KIND_APPEND,
        KIND_FULL
    } result_kind_t;

    typedef struct packed {
        logic         capture;
        logic         rd_en;
        logic         idx_inc;
        logic         load_out;
        result_kind_t kind;
    } dp_cmd_t;

    typedef struct packed {
        logic tgt_fail;
        logic src_fail;
        logic cnt_zero;
        logic cnt_full;
        logic match;
        logic last;
    } dp_status_t;

endpackage

// ===== rtl/core/connection_innovation_registry_unit.sv =====
// Top level of the connection innovation registry; uses cir_pkg, cir_ctrl,
// cir_dp and the assertion macro header.
// Each request on the input channel (source_node, target_node) yields one
// result (innovation_index, newly_added, status) on the output channel.
// Both channels use valid and ready; the configuration channel writes
// input_count (index 0) and output_count (index 1) and is always ready.
// A request is taken in the idle state and checked against the node ranges
// in the check state; the stored pairs are then read and compared one entry
// at a time, alternating read and compare states, until a match or the last
// entry. A rejected request or an empty table goes straight to the result
// state. The next request is taken only after the previous result is loaded
// into the output register, so requests are processed one at a time; one
// that is scanned takes longer, as the single-port pair memory is read per entry.
// Reset clears the entry count and sets both counts to one; the memory
// itself is not cleared, as entries beyond the count are never read.
// A stalled receiver holds the result in the output register; a further
// request is still accepted and processed, and waits until that result goes.
`timescale 1ns / 1ps

`include "connection_innovation_registry_unit_assert.svh"

module connection_innovation_registry_unit
    import cir_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    parameter int NODE_BITS   = DEFAULT_NODE_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [COUNT_W-1:0]     cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [NODE_W-1:0]      source_node,
    input  logic [NODE_W-1:0]      target_node,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [INDEX_W-1:0]     innovation_index,
    output logic                   newly_added,
    output logic [STATUS_W-1:0]    status
);

    dp_cmd_t    cmd;
    dp_status_t stat;
    logic       cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    cir_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    cir_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .NODE_BITS   (NODE_BITS)
    ) u_dp
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .source_node      (source_node),
        .target_node      (target_node),
        .cmd              (cmd),
        .stat             (stat),
        .innovation_index (innovation_index),
        .newly_added      (newly_added),
        .status           (status)
    );

    `CIR_ASSERT_SAME(a_new_is_ok, clk, rst_n, out_valid && newly_added, status == STATUS_OK)
    `CIR_ASSERT_SAME(a_error_zero, clk, rst_n, out_valid && (status != STATUS_OK), (innovation_index == '0) && !newly_added)
    `CIR_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready)
    `CIR_ASSERT_SAME(a_no_append_full, clk, rst_n, cmd.load_out && (cmd.kind == KIND_APPEND), !stat.cnt_full)

endmodule

// ===== rtl/core/cir_dp.sv =====
// Datapath of the connection innovation registry: pair memory, scan index,
// entry count, configuration registers and result register. Uses cir_pkg.
`timescale 1ns / 1ps

module cir_dp
    import cir_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    parameter int NODE_BITS   = DEFAULT_NODE_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [COUNT_W-1:0]     cfg_data,
    input  logic [NODE_W-1:0]      source_node,
    input  logic [NODE_W-1:0]      target_node,
    input  dp_cmd_t                cmd,
    output dp_status_t             stat,
    output logic [INDEX_W-1:0]     innovation_index,
    output logic                   newly_added,
    output logic [STATUS_W-1:0]    status
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W = NODE_BITS + COUNT_W + 1;

    logic [2*NODE_BITS-1:0] mem [TABLE_DEPTH];

    logic [NODE_BITS-1:0]   src_reg;
    logic [NODE_BITS-1:0]   dst_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [2*NODE_BITS-1:0] rd_data_reg;
    logic [COUNT_W-1:0]     input_count_reg;
    logic [COUNT_W-1:0]     output_count_reg;
    logic [INDEX_W-1:0]     index_out_reg;
    logic                   new_out_reg;
    logic [STATUS_W-1:0]    status_out_reg;

    logic [NODE_BITS+NODE_W-1:0] src_wide;
    logic [NODE_BITS+NODE_W-1:0] dst_wide;
    logic [CMP_W-1:0]            src_cmp;
    logic [CMP_W-1:0]            dst_cmp;
    logic [CMP_W-1:0]            first_out;
    logic [CMP_W-1:0]            past_out;
    logic [NODE_BITS-1:0]        rd_src;
    logic [NODE_BITS-1:0]        rd_dst;
    logic [IDX_W+INDEX_W-1:0]    idx_wide;
    logic [CNT_W+INDEX_W-1:0]    cnt_wide;
    logic [IDX_W-1:0]            wr_addr;
    logic                        append;

    // Node ids are masked (or zero-extended) to the stored node width.
    assign src_wide = {{NODE_BITS{1'b0}}, source_node};
    assign dst_wide = {{NODE_BITS{1'b0}}, target_node};

    assign src_cmp   = CMP_W'(src_reg);
    assign dst_cmp   = CMP_W'(dst_reg);
    assign first_out = CMP_W'(input_count_reg) + CMP_W'(1);
    assign past_out  = CMP_W'(input_count_reg) + CMP_W'(output_count_reg) + CMP_W'(1);

    assign rd_src = rd_data_reg[2*NODE_BITS-1:NODE_BITS];
    assign rd_dst = rd_data_reg[NODE_BITS-1:0];

    assign stat.tgt_fail = dst_cmp < first_out;
    assign stat.src_fail = (src_cmp >= first_out) && (src_cmp < past_out);
    assign stat.cnt_zero = count_reg == '0;
    assign stat.cnt_full = count_reg == CNT_W'(TABLE_DEPTH);
    assign stat.match    = ((rd_src == src_reg) && (rd_dst == dst_reg))
                        || ((rd_src == dst_reg) && (rd_dst == src_reg));
    assign stat.last     = (CNT_W'(idx_reg) + CNT_W'(1)) == count_reg;

    assign idx_wide = {{INDEX_W{1'b0}}, idx_reg};
    assign cnt_wide = {{INDEX_W{1'b0}}, count_reg};
    assign wr_addr  = count_reg[IDX_W-1:0];
    assign append   = cmd.load_out && (cmd.kind == KIND_APPEND);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            input_count_reg  <= COUNT_W'(1);
            output_count_reg <= COUNT_W'(1);
            idx_reg          <= '0;
        end
        else
        begin
            if (cfg_write && (cfg_index == REG_INPUT_COUNT))
            begin
                input_count_reg <= cfg_data;
            end
            if (cfg_write && (cfg_index == REG_OUTPUT_COUNT))
            begin
                output_count_reg <= cfg_data;
            end
            if (cmd.capture)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            if (append)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            src_reg <= src_wide[NODE_BITS-1:0];
            dst_reg <= dst_wide[NODE_BITS-1:0];
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[idx_reg];
        end
        if (append)
        begin
            mem[wr_addr] <= {src_reg, dst_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            unique case (cmd.kind)
                KIND_TARGET:
                begin
                    index_out_reg  <= '0;
                    new_out_reg    <= 1'b0;
                    status_out_reg <= STATUS_TARGET_IN;
                end
                KIND_SOURCE:
                begin
                    index_out_reg  <= '0;
                    new_out_reg    <= 1'b0;
                    status_out_reg <= STATUS_SOURCE_OUT;
                end
                KIND_FOUND:
                begin
                    index_out_reg  <= idx_wide[INDEX_W-1:0];
                    new_out_reg    <= 1'b0;
                    status_out_reg <= STATUS_OK;
                end
                KIND_APPEND:
                begin
                    index_out_reg  <= cnt_wide[INDEX_W-1:0];
                    new_out_reg    <= 1'b1;
                    status_out_reg <= STATUS_OK;
                end
                default:
                begin
                    index_out_reg  <= '0;
                    new_out_reg    <= 1'b0;
                    status_out_reg <= STATUS_FULL;
                end
            endcase
        end
    end

    assign innovation_index = index_out_reg;
    assign newly_added      = new_out_reg;
    assign status           = status_out_reg;

endmodule

// ===== rtl/core/cir_ctrl.sv =====
// Controller of the connection innovation registry: request sequencing,
// table scan and result handshake. Uses cir_pkg.
`timescale 1ns / 1ps

module cir_ctrl
    import cir_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t stat,
    output dp_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_CMP    = 3'd3;
    localparam logic [2:0] S_RESULT = 3'd4;

    logic [2:0]   state_reg;
    logic [2:0]   state_next;
    result_kind_t kind_reg;
    result_kind_t kind_next;
    logic         out_valid_reg;
    logic         out_valid_next;

    always_comb
    begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        in_ready    = 1'b0;
        cmd.capture  = 1'b0;
        cmd.rd_en    = 1'b0;
        cmd.idx_inc  = 1'b0;
        cmd.load_out = 1'b0;
        cmd.kind     = kind_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                // The target check takes precedence over the source check.
                priority if (stat.tgt_fail)
                begin
                    kind_next  = KIND_TARGET;
                    state_next = S_RESULT;
                end
                else if (stat.src_fail)
                begin
                    kind_next  = KIND_SOURCE;
                    state_next = S_RESULT;
                end
                else if (stat.cnt_zero)
                begin
                    kind_next  = KIND_APPEND;
                    state_next = S_RESULT;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                priority if (stat.match)
                begin
                    kind_next  = KIND_FOUND;
                    state_next = S_RESULT;
                end
                else if (stat.last)
                begin
                    kind_next  = stat.cnt_full ? KIND_FULL : KIND_APPEND;
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_RESULT:
            begin
                // Wait here only while an earlier result is still held back.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            kind_reg      <= KIND_TARGET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== verif/tb_connection_innovation_registry_unit.sv =====
// Self-checking testbench for connection_innovation_registry_unit.
// Depends on cir_pkg and the unit itself. A predictor keeps its own pair table and counts
// and checks every result, in order, under random idling on both channels.
`timescale 1ns / 1ps

module tb_connection_innovation_registry_unit;
    import cir_pkg::*;

    localparam int TABLE_DEPTH = DEFAULT_TABLE_DEPTH;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 108;

    typedef struct packed {
        logic [INDEX_W-1:0]  index;
        logic                added;
        logic [STATUS_W-1:0] code;
    } innovation_t;

    typedef enum logic [1:0] {
        STEP_REQUEST,
        STEP_CONFIG,
        STEP_DRAIN
    } step_kind_t;

    typedef struct {
        step_kind_t             kind;
        logic [NODE_W-1:0]      src;
        logic [NODE_W-1:0]      dst;
        logic [CFG_INDEX_W-1:0] reg_sel;
        logic [COUNT_W-1:0]     value;
    } backlog_entry_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [COUNT_W-1:0]     cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [NODE_W-1:0]      source_node = '0;
    logic [NODE_W-1:0]      target_node = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [INDEX_W-1:0]     innovation_index;
    logic                   newly_added;
    logic [STATUS_W-1:0]    status;

    // Predictor state.
    logic [NODE_W-1:0]  stored_src [TABLE_DEPTH];
    logic [NODE_W-1:0]  stored_dst [TABLE_DEPTH];
    int                 entry_total = 0;
    logic [COUNT_W-1:0] reg_inputs = 11'd1;
    logic [COUNT_W-1:0] reg_outputs = 11'd1;

    backlog_entry_t request_backlog [$];
    innovation_t    pending_innovations [$];

    int steps_queued = 0;
    int requests_accepted = 0;
    int configs_written = 0;
    int drains_done = 0;
    int results_checked = 0;
    int fail_count = 0;
    int quiet_cycles = 0;
    int cycle_count = 0;
    int status_tally [4] = '{0, 0, 0, 0};
    int plan_inputs = 1;
    int plan_outputs = 1;

    // One long stretch in the middle of the run runs with no idling on either side.
    wire calm_window = (requests_accepted >= 300) && (requests_accepted < 420);

    connection_innovation_registry_unit #(
        .TABLE_DEPTH (DEFAULT_TABLE_DEPTH),
        .NODE_BITS   (DEFAULT_NODE_BITS)
    ) uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .source_node      (source_node),
        .target_node      (target_node),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .innovation_index (innovation_index),
        .newly_added      (newly_added),
        .status           (status)
    );

    always #4 clk = ~clk;

    // Earliest entry holding the pair in either direction, or -1.
    function automatic int pair_index(input logic [NODE_W-1:0] src, input logic [NODE_W-1:0] dst);
        int hit;
        hit = -1;
        for (int i = entry_total - 1; i >= 0; i--)
        begin
            if ((stored_src[i] == src && stored_dst[i] == dst) ||
                (stored_src[i] == dst && stored_dst[i] == src))
                hit = i;
        end
        return hit;
    endfunction

    function automatic innovation_t registry_lookup(input logic [NODE_W-1:0] src,
                                                    input logic [NODE_W-1:0] dst);
        innovation_t res;
        int          first_output;
        int          past_output;
        int          hit;
        res          = '0;
        first_output = int'(reg_inputs) + 1;
        past_output  = int'(reg_inputs) + int'(reg_outputs) + 1;
        if (int'(dst) < first_output)
            res.code = STATUS_TARGET_IN;
        else if (int'(src) >= first_output && int'(src) < past_output)
            res.code = STATUS_SOURCE_OUT;
        else
        begin
            hit = pair_index(src, dst);
            if (hit >= 0)
            begin
                res.index = INDEX_W'(hit);
                res.code  = STATUS_OK;
            end
            else if (entry_total >= TABLE_DEPTH)
                res.code = STATUS_FULL;
            else
            begin
                stored_src[entry_total] = src;
                stored_dst[entry_total] = dst;
                res.index   = INDEX_W'(entry_total);
                res.added   = 1'b1;
                res.code    = STATUS_OK;
                entry_total = entry_total + 1;
            end
        end
        return res;
    endfunction

    function automatic void registry_config(input logic [CFG_INDEX_W-1:0] sel,
                                            input logic [COUNT_W-1:0] value);
        if (sel == REG_INPUT_COUNT)
            reg_inputs = value;
        else if (sel == REG_OUTPUT_COUNT)
            reg_outputs = value;
    endfunction

    // Driver: feeds requests and register writes from the backlog.
    always @(posedge clk or negedge rst_n)
    begin
        backlog_entry_t step;
        logic           nxt_in_valid;
        logic           nxt_cfg_valid;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            cfg_valid <= 1'b0;
        end
        else
        begin
            nxt_in_valid  = in_valid;
            nxt_cfg_valid = cfg_valid;
            if (in_valid && in_ready)
            begin
                pending_innovations.insert(pending_innovations.size(),
                                           registry_lookup(source_node, target_node));
                requests_accepted++;
                nxt_in_valid = 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                registry_config(cfg_index, cfg_data);
                configs_written++;
                nxt_cfg_valid = 1'b0;
            end
            if (pending_innovations.size() == 0 && !nxt_in_valid)
                quiet_cycles++;
            else
                quiet_cycles = 0;
            if (!nxt_in_valid && !nxt_cfg_valid && request_backlog.size() != 0)
            begin
                step = request_backlog[0];
                case (step.kind)
                    STEP_REQUEST:
                        if (calm_window || $urandom_range(99) >= 19)
                        begin
                            nxt_in_valid = 1'b1;
                            source_node  <= step.src;
                            target_node  <= step.dst;
                            void'(request_backlog.pop_front());
                        end
                    STEP_CONFIG:
                        // Registers change only once the block has drained.
                        if (quiet_cycles >= 4)
                        begin
                            nxt_cfg_valid = 1'b1;
                            cfg_index     <= step.reg_sel;
                            cfg_data      <= step.value;
                            void'(request_backlog.pop_front());
                        end
                    default:
                        if (quiet_cycles >= 1)
                        begin
                            drains_done++;
                            void'(request_backlog.pop_front());
                        end
                endcase
            end
            in_valid  <= nxt_in_valid;
            cfg_valid <= nxt_cfg_valid;
        end
    end

    // Monitor: checks each result against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        innovation_t predicted;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                results_checked++;
                status_tally[status]++;
                if (pending_innovations.size() == 0)
                begin
                    $error("unexpected result: index %0d, added %0d, status %0d",
                           innovation_index, newly_added, status);
                    fail_count++;
                end
                else
                begin
                    predicted = pending_innovations.pop_front();
                    if (innovation_index !== predicted.index)
                    begin
                        $error("innovation_index: expected %0d, actual %0d",
                               predicted.index, innovation_index);
                        fail_count++;
                    end
                    if (newly_added !== predicted.added)
                    begin
                        $error("newly_added: expected %0d, actual %0d",
                               predicted.added, newly_added);
                        fail_count++;
                    end
                    if (status !== predicted.code)
                    begin
                        $error("status: expected %0d, actual %0d", predicted.code, status);
                        fail_count++;
                    end
                end
            end
            out_ready <= calm_window || ($urandom_range(99) >= 19);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** connection_innovation_registry_unit: FAILED **");
            $finish;
        end
    end

    task automatic push_step(input backlog_entry_t step);
        while (request_backlog.size() >= 2)
            @(posedge clk);
        request_backlog.insert(request_backlog.size(), step);
        steps_queued++;
    endtask

    task automatic queue_request(input int src, input int dst);
        backlog_entry_t step;
        step         = '{STEP_REQUEST, NODE_W'(src), NODE_W'(dst), '0, '0};
        push_step(step);
    endtask

    task automatic queue_config(input int inputs, input int outputs);
        backlog_entry_t step;
        step = '{STEP_CONFIG, '0, '0, REG_INPUT_COUNT, COUNT_W'(inputs)};
        push_step(step);
        step = '{STEP_CONFIG, '0, '0, REG_OUTPUT_COUNT, COUNT_W'(outputs)};
        push_step(step);
        plan_inputs  = inputs;
        plan_outputs = outputs;
    endtask

    task automatic queue_drain();
        backlog_entry_t step;
        step = '{STEP_DRAIN, '0, '0, '0, '0};
        push_step(step);
    endtask

    task automatic wait_for_quiet();
        while (configs_written + drains_done + results_checked != steps_queued)
            @(posedge clk);
    endtask

    // A pair that passes both range checks under the planned counts and is not yet stored.
    task automatic pick_open_pair(output int src, output int dst);
        do
        begin
            dst = $urandom_range(65535, plan_inputs + 1);
            if ($urandom_range(1) == 0)
                src = $urandom_range(plan_inputs, 0);
            else
                src = $urandom_range(65535, plan_inputs + plan_outputs + 1);
        end
        while (pair_index(NODE_W'(src), NODE_W'(dst)) >= 0);
    endtask

    // Node ids on either side of each range edge for the planned counts.
    task automatic queue_boundaries();
        queue_request(0, plan_inputs);
        queue_request(0, plan_inputs + 1);
        queue_request(plan_inputs + 1, plan_inputs + 1);
        queue_request(plan_inputs + plan_outputs, 65535);
        queue_request(plan_inputs + plan_outputs + 1, plan_inputs + 1);
    endtask

    task automatic queue_random_request();
        int pick;
        int src;
        int dst;
        int slot;
        pick = $urandom_range(99);
        if (pick < 55 && entry_total > 0)
        begin
            slot = $urandom_range(entry_total - 1, 0);
            if ($urandom_range(1) == 0)
                queue_request(stored_src[slot], stored_dst[slot]);
            else
                queue_request(stored_dst[slot], stored_src[slot]);
        end
        else if (pick < 80)
        begin
            pick_open_pair(src, dst);
            queue_request(src, dst);
        end
        else if (pick < 88)
            queue_request($urandom_range(65535), $urandom_range(plan_inputs, 0));
        else if (pick < 94 && plan_outputs > 0)
            queue_request($urandom_range(plan_inputs + plan_outputs, plan_inputs + 1),
                          $urandom_range(65535));
        else
            queue_request($urandom_range(65535), $urandom_range(65535));
    endtask

    initial
    begin
        int phase_inputs [PHASES];
        int phase_outputs [PHASES];
        int src;
        int dst;
        phase_inputs  = '{4, 2047, 0, 1024, 1, 0, 0};
        phase_outputs = '{3, 2047, 0, 1, 1024, 0, 0};
        phase_inputs[5]  = $urandom_range(1024, 1);
        phase_outputs[5] = $urandom_range(1024, 1);
        phase_inputs[6]  = $urandom_range(16, 1);
        phase_outputs[6] = $urandom_range(16, 1);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed requests under the reset counts: bias 0, input 1, output 2.
        queue_request(0, 3);
        queue_request(0, 3);
        queue_request(3, 4);
        queue_request(4, 3);
        queue_request(5, 5);
        queue_request(5, 5);
        queue_request(3, 1);
        queue_request(3, 0);
        queue_request(2, 5);
        queue_request(2, 1);
        queue_request(0, 65535);
        queue_request(65535, 65535);
        queue_request(65535, 2);
        queue_request(0, 0);
        queue_request(65535, 0);
        queue_request(1, 2);
        queue_request(2, 65535);
        queue_request(1, 65535);
        queue_boundaries();

        for (int p = 0; p < PHASES; p++)
        begin
            queue_config(phase_inputs[p], phase_outputs[p]);
            queue_boundaries();
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // Hold the sender back once until every result is home.
                if (p == 2 && n == PHASE_ITEMS / 2)
                    queue_drain();
                queue_random_request();
            end
        end

        // Fill the table to the last slot, then probe it while full.
        queue_config(2, 2);
        wait_for_quiet();
        while (entry_total < TABLE_DEPTH)
        begin
            pick_open_pair(src, dst);
            queue_request(src, dst);
            wait_for_quiet();
        end
        queue_request(stored_src[TABLE_DEPTH - 1], stored_dst[TABLE_DEPTH - 1]);
        queue_request(stored_dst[0], stored_src[0]);
        for (int n = 0; n < 24; n++)
            queue_random_request();

        wait_for_quiet();
        repeat (40) @(posedge clk);

        $display("Run covered %0d requests over %0d register writes;",
                 requests_accepted, configs_written);
        $display("the table ended with %0d entries.", entry_total);
        $display("Results by status: ok %0d, target input %0d, source output %0d, full %0d.",
                 status_tally[0], status_tally[1], status_tally[2], status_tally[3]);
        if (fail_count == 0 && pending_innovations.size() == 0)
            $display("** connection_innovation_registry_unit: PASSED **");
        else
            $display("** connection_innovation_registry_unit: FAILED **");
        $finish;
    end

endmodule
